/* src/opke_pkg.sv */
// ----------------------------------------------------------------------------
// opke_pkg
// Shared types and constants of the order-preserving key encoder.
// ----------------------------------------------------------------------------
package opke_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_INT      = 2'd0,
    FUNC_STR_BYTE = 2'd1,
    FUNC_STR_END  = 2'd2
  } func_e;

  // Integer width codes; anything above SIZE_16B saturates to 16 bytes
  localparam logic [2:0] SIZE_1B  = 3'd0;
  localparam logic [2:0] SIZE_2B  = 3'd1;
  localparam logic [2:0] SIZE_4B  = 3'd2;
  localparam logic [2:0] SIZE_8B  = 3'd3;
  localparam logic [2:0] SIZE_16B = 3'd4;

  localparam logic [7:0] ESC_BYTE  = 8'h00;
  localparam logic [7:0] ESC_MARK  = 8'h01;

  localparam int unsigned MaxBytes  = 16;
  localparam int unsigned WordW     = MaxBytes * 8;
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned CmdDepth  = 2;
  localparam int unsigned CmdPtrW   = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW   = $clog2(CmdDepth + 1);

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  size_code;
    logic        signed_flag;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [7:0]  str_byte;
    logic        final_component;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // One byte run: first byte in the top byte lane, last_idx = byte count - 1
  typedef struct packed {
    logic [WordW-1:0] bytes;
    logic [IdxW-1:0]  last_idx;
  } cmd_t;

endpackage

/* src/order_preserving_key_encoder_core.sv */
// ----------------------------------------------------------------------------
// order_preserving_key_encoder_core
// Memcomparable key encoder: turns key components into an ordered byte stream.
// ----------------------------------------------------------------------------
// Each input beat is one piece of a composite key: an integer component
// (1, 2, 4, 8 or 16 bytes, sent most significant byte first, top bit
// inverted when signed), one string content byte, or the end of a string
// component. For a string that is not the last component a 0x00 byte goes
// out as 0x00 0x01 and the end emits 0x00 0x00; for the last component bytes
// go raw and the end emits nothing. Every output beat carries one byte, and
// run_last marks the final byte caused by an input beat. While the consumer
// pops, the output stream runs at one byte per cycle: a single-byte item
// sustains one input beat per cycle, while a multi-byte item occupies the
// serializer until its last byte, so wide integers and escapes hold off
// input once the two-entry run queue is full. An accepted beat passes the
// run queue, then the output register. Items that produce nothing (unknown
// function code, end of the last string) are accepted and dropped.
// ----------------------------------------------------------------------------
module order_preserving_key_encoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  opke_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output opke_pkg::out_item_t out_item_o
);
  import opke_pkg::*;

  // classifier -> run queue
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;

  // run queue -> serializer
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_out;

  // Input side stalls only on a full run queue.
  assign full = cmd_full;

  opke_front u_front (
    .push       (push),
    .cmd_full_i (cmd_full),
    .in_item_i  (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  opke_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  // Serializer owns the output register; pop/empty face the consumer.
  opke_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

/* src/opke_front.sv */
// ----------------------------------------------------------------------------
// opke_front
// Classifies an input beat and turns it into a left-aligned byte run.
// ----------------------------------------------------------------------------
module opke_front (
  input  logic              push,
  input  logic              cmd_full_i,
  input  opke_pkg::in_item_t in_item_i,
  output logic              cmd_push_o,
  output opke_pkg::cmd_t    cmd_o
);
  import opke_pkg::*;

  logic             has_cmd;
  logic [WordW-1:0] aligned;

  always_comb begin
    case (in_item_i.size_code) inside
      SIZE_1B: aligned = {in_item_i.value_low[7:0],  120'd0};
      SIZE_2B: aligned = {in_item_i.value_low[15:0], 112'd0};
      SIZE_4B: aligned = {in_item_i.value_low[31:0], 96'd0};
      SIZE_8B: aligned = {in_item_i.value_low,       64'd0};
      default: aligned = {in_item_i.value_high, in_item_i.value_low};
    endcase
  end

  always_comb begin
    has_cmd        = 1'b1;
    cmd_o.bytes    = '0;
    cmd_o.last_idx = '0;
    case (in_item_i.func)
      FUNC_INT: begin
        cmd_o.bytes = aligned;
        cmd_o.bytes[WordW-1] = aligned[WordW-1] ^ in_item_i.signed_flag;
        case (in_item_i.size_code) inside
          SIZE_1B: cmd_o.last_idx = IdxW'(0);
          SIZE_2B: cmd_o.last_idx = IdxW'(1);
          SIZE_4B: cmd_o.last_idx = IdxW'(3);
          SIZE_8B: cmd_o.last_idx = IdxW'(7);
          default: cmd_o.last_idx = IdxW'(MaxBytes - 1);
        endcase
      end
      FUNC_STR_BYTE: begin
        if (in_item_i.final_component || in_item_i.str_byte != ESC_BYTE) begin
          cmd_o.bytes = {in_item_i.str_byte, (WordW-8)'(0)};
        end else begin
          cmd_o.bytes    = {ESC_BYTE, ESC_MARK, (WordW-16)'(0)};
          cmd_o.last_idx = IdxW'(1);
        end
      end
      FUNC_STR_END: begin
        // terminator only for a component that is not the last one
        has_cmd        = !in_item_i.final_component;
        cmd_o.bytes    = {ESC_BYTE, ESC_BYTE, (WordW-16)'(0)};
        cmd_o.last_idx = IdxW'(1);
      end
      default: has_cmd = 1'b0;
    endcase
  end

  assign cmd_push_o = push && !cmd_full_i && has_cmd;

endmodule

/* src/opke_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// opke_cmd_fifo
// Short run queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module opke_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  opke_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output opke_pkg::cmd_t cmd_o
);
  import opke_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  function automatic logic [CmdPtrW-1:0] ptr_inc(input logic [CmdPtrW-1:0] p);
    ptr_inc = (p == CmdPtrW'(CmdDepth - 1)) ? '0 : p + CmdPtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CmdCntW'(push_i) - CmdCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("run queue read while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CmdCntW'(CmdDepth))
    else $error("run queue count out of range");
`endif

endmodule

/* src/opke_back.sv */
// ----------------------------------------------------------------------------
// opke_back
// Serializer: drains queued byte runs one byte per beat into the output
// register.
// ----------------------------------------------------------------------------
module opke_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  opke_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  logic               pop,
  output opke_pkg::out_item_t out_item_o
);
  import opke_pkg::*;

  logic             busy_q, busy_d;
  logic [WordW-1:0] sh_q, sh_d;
  logic [IdxW-1:0]  rem_q, rem_d;
  logic             ovld_q, ovld_d;
  out_item_t        out_q, out_d;
  logic             adv;

  // output register free or being taken this cycle
  assign adv       = !ovld_q || pop;
  assign cmd_pop_o = adv && !busy_q && !cmd_empty_i;

  always_comb begin
    busy_d = busy_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    ovld_d = ovld_q;
    out_d  = out_q;
    if (adv) begin
      if (busy_q) begin
        out_d.out_byte = sh_q[WordW-1 -: 8];
        out_d.run_last = (rem_q == '0);
        ovld_d         = 1'b1;
        sh_d           = sh_q << 8;
        rem_d          = rem_q - IdxW'(1);
        busy_d         = (rem_q != '0);
      end else if (!cmd_empty_i) begin
        out_d.out_byte = cmd_i.bytes[WordW-1 -: 8];
        out_d.run_last = (cmd_i.last_idx == '0);
        ovld_d         = 1'b1;
        sh_d           = cmd_i.bytes << 8;
        rem_d          = cmd_i.last_idx - IdxW'(1);
        busy_d         = (cmd_i.last_idx != '0);
      end else begin
        ovld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  assign empty      = !ovld_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_busy_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ovld_q)
    else $error("run in flight without a pending output byte");

  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_q.run_last)
    else $error("run marked finished while bytes remain");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !cmd_pop_o)
    else $error("new run taken while one is draining");
`endif

endmodule
